// ===== rtl/mast_pkg.sv =====
`default_nettype none
package mast_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TIME_WIDTH_DEF   = 32;
	localparam int CW = 28;
	localparam int DW = 44;
	localparam int CNT_W = 6;
	localparam logic signed [31:0] DEG90  = 32'sd5898240;
	localparam logic signed [31:0] DEG180 = 32'sd11796480;
	localparam logic signed [31:0] DEG270 = 32'sd17694720;
	localparam logic signed [31:0] DEG360 = 32'sd23592960;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	typedef struct packed {
		logic load;
		logic cordic_step;
		logic head;
		logic mult;
		logic div_init;
		logic div_step;
		logic commit;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
	} sts_t;

	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd2949120;
			5'd1: v = 32'd1740967;
			5'd2: v = 32'd919879;
			5'd3: v = 32'd466945;
			5'd4: v = 32'd234379;
			5'd5: v = 32'd117304;
			5'd6: v = 32'd58666;
			5'd7: v = 32'd29335;
			5'd8: v = 32'd14668;
			5'd9: v = 32'd7334;
			5'd10: v = 32'd3667;
			5'd11: v = 32'd1833;
			5'd12: v = 32'd917;
			5'd13: v = 32'd458;
			5'd14: v = 32'd229;
			5'd15: v = 32'd115;
			5'd16: v = 32'd57;
			5'd17: v = 32'd29;
			5'd18: v = 32'd14;
			5'd19: v = 32'd7;
			5'd20: v = 32'd4;
			5'd21: v = 32'd2;
			5'd22: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/mast_ctrl.sv =====
`default_nettype none
module mast_ctrl #(
	parameter int CORDIC_STEPS = mast_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       reading_valid,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire mast_pkg::sts_t sts,
	output mast_pkg::cmd_t  cmd
);
	typedef enum logic [2:0] {IDLE, CORD, HEAD, MULT, DIV, FIN} state_t;
	state_t state_q;
	logic [mast_pkg::CNT_W-1:0] cnt_q;
	logic slot_free;

	assign slot_free = !(out_valid && out_stall);
	assign in_stall = (state_q != IDLE);

	always_comb begin
		cmd = '0;
		cmd.idx = cnt_q[4:0];
		unique case (state_q)
			IDLE: cmd.load = in_valid;
			CORD: cmd.cordic_step = 1'b1;
			HEAD: cmd.head = 1'b1;
			MULT: cmd.mult = 1'b1;
			DIV: cmd.div_step = 1'b1;
			FIN: cmd.commit = slot_free;
			default: ;
		endcase
		if (state_q == MULT) cmd.div_init = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					cnt_q <= '0;
					if (in_valid) state_q <= reading_valid ? CORD : FIN;
				end
				CORD: begin
					if (cnt_q == mast_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= HEAD;
					end else cnt_q <= cnt_q + 1'b1;
				end
				HEAD: state_q <= MULT;
				MULT: state_q <= DIV;
				DIV: begin
					if (sts.dt_zero) state_q <= FIN;
					else if (cnt_q == mast_pkg::CNT_W'(mast_pkg::DW - 1)) begin
						cnt_q <= '0;
						state_q <= FIN;
					end else cnt_q <= cnt_q + 1'b1;
				end
				FIN: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mast_dp.sv =====
`default_nettype none
module mast_dp #(
	parameter int TIME_WIDTH = mast_pkg::TIME_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mast_pkg::cmd_t     cmd,
	output mast_pkg::sts_t          sts,
	input  wire logic signed [15:0] x_reading,
	input  wire logic signed [15:0] y_reading,
	input  wire logic               reading_valid,
	input  wire logic [31:0]        time_us,
	output logic                    updated,
	output logic signed [31:0]      total_angle,
	output logic signed [31:0]      smoothed_speed
);
	localparam int CW = mast_pkg::CW;
	localparam int DW = mast_pkg::DW;
	localparam int RW = ((TIME_WIDTH > DW) ? TIME_WIDTH : DW) + 1;

	logic signed [15:0] xin_q, yin_q;
	logic vin_q;
	logic [31:0] tin_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic signed [31:0] heading_q, delta_q;
	logic [TIME_WIDTH-1:0] dt_q;
	logic [DW-1:0] div_q, quo_q;
	logic [RW-1:0] rem_q;
	logic [31:0] last_time_q;
	logic signed [31:0] last_heading_q, acc_q, avg_q;
	logic upd_q;

	logic signed [CW-1:0] x0, y0, xsh, ysh;
	logic signed [31:0] head_c, dlt, dlt_u, zw;
	logic [23:0] mag;
	logic [RW-1:0] r_sh, dte;
	logic signed [31:0] raw;
	logic signed [32:0] sum;

	assign sts.dt_zero = (dt_q == '0);
	assign updated = upd_q;
	assign total_angle = acc_q;
	assign smoothed_speed = avg_q;

	always_comb begin
		x0 = CW'(x_reading) <<< 8;
		y0 = CW'(y_reading) <<< 8;
		xsh = cx_q >>> cmd.idx;
		ysh = cy_q >>> cmd.idx;
		zw = cz_q;
		if (cz_q < 0) zw = cz_q + mast_pkg::DEG360;
		else if (cz_q >= mast_pkg::DEG360) zw = cz_q - mast_pkg::DEG360;
		if (xin_q == 0)
			head_c = (yin_q == 0) ? 32'sd0 : ((yin_q > 0) ? mast_pkg::DEG90 : mast_pkg::DEG270);
		else if (yin_q == 0)
			head_c = (xin_q > 0) ? 32'sd0 : mast_pkg::DEG180;
		else head_c = zw;
		dlt = head_c - last_heading_q;
		dlt_u = dlt;
		if (!(dlt < mast_pkg::DEG180 && dlt > -mast_pkg::DEG180))
			dlt_u = (dlt > 0) ? dlt - mast_pkg::DEG360 : dlt + mast_pkg::DEG360;
		mag = (delta_q < 0) ? 24'(-delta_q) : delta_q[23:0];
		r_sh = {rem_q[RW-2:0], div_q[DW-1]};
		dte = RW'(dt_q);
		if (sts.dt_zero)
			raw = (delta_q > 0) ? 32'sh7fffffff : ((delta_q < 0) ? 32'sh80000000 : 32'sd0);
		else if (delta_q >= 0)
			raw = (quo_q > DW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(quo_q[31:0]);
		else
			raw = (quo_q > DW'(33'h80000000)) ? 32'sh80000000 : -$signed(quo_q[31:0]);
		sum = 33'(avg_q) + 33'(raw);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xin_q <= x_reading;
			yin_q <= y_reading;
			vin_q <= reading_valid;
			tin_q <= time_us;
			if (x_reading < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= mast_pkg::DEG180;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end
		if (cmd.cordic_step) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + ysh;
				cy_q <= cy_q - xsh;
				cz_q <= cz_q + $signed(mast_pkg::atan_tab(cmd.idx));
			end else begin
				cx_q <= cx_q - ysh;
				cy_q <= cy_q + xsh;
				cz_q <= cz_q - $signed(mast_pkg::atan_tab(cmd.idx));
			end
		end
		if (cmd.head) begin
			heading_q <= head_c;
			delta_q <= dlt_u;
			dt_q <= TIME_WIDTH'(tin_q) - TIME_WIDTH'(last_time_q);
		end
		if (cmd.mult) div_q <= DW'(mag) * DW'(mast_pkg::US_PER_S);
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (r_sh >= dte) begin
				rem_q <= r_sh - dte;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= r_sh;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			div_q <= {div_q[DW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			last_heading_q <= '0;
			acc_q <= '0;
			avg_q <= '0;
			upd_q <= 1'b0;
		end else if (cmd.commit) begin
			upd_q <= vin_q;
			if (vin_q) begin
				last_time_q <= tin_q;
				last_heading_q <= heading_q;
				acc_q <= acc_q + delta_q;
				avg_q <= sum[32:1];
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/magnetic_angle_speed_tracker.sv =====
// Sequence for a valid reading: accept, CORDIC_STEPS CORDIC steps, HEAD, MULT, the serial
// divider (left at once when dt is 0) and FIN; an invalid one goes from accept to FIN.
// One item at a time: in_stall is high until FIN hands the result on. The shared
// CORDIC stage and the 44-step serial divider take up most of the time per item.
// A new item is accepted while a result waits.
// Reset (arst_n low) clears the time, heading, angle and speed state to zero.
`default_nettype none
module magnetic_angle_speed_tracker #(
	parameter int CORDIC_STEPS = mast_pkg::CORDIC_STEPS_DEF,
	parameter int TIME_WIDTH   = mast_pkg::TIME_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] x_reading,
	input  wire logic signed [15:0] y_reading,
	input  wire logic               reading_valid,
	input  wire logic [31:0]        time_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    updated,
	output logic signed [31:0]      total_angle,
	output logic signed [31:0]      smoothed_speed
);
	mast_pkg::cmd_t cmd;
	mast_pkg::sts_t sts;

	mast_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.reading_valid(reading_valid), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	mast_dp #(.TIME_WIDTH(TIME_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.x_reading(x_reading), .y_reading(y_reading), .reading_valid(reading_valid),
		.time_us(time_us), .updated(updated), .total_angle(total_angle),
		.smoothed_speed(smoothed_speed)
	);
endmodule
`default_nettype wire
